/* rtl/cat_pkg.sv */
`timescale 1ns / 1ps

package cat_pkg;

  localparam int CONNECTIONS_DEF = 16;
  localparam int LOG_DEPTH_DEF   = 256;
  localparam int LIST_DEPTH_DEF  = 64;

  localparam int REQ_W  = 2;
  localparam int CONN_W = 4;
  localparam int ID_W   = 64;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_SENT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADCONN = 2'd2;

  // Operation as decided by the front end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SENT,
    OP_ACK,
    OP_QUERY,
    OP_BADCONN
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CONN_W-1:0] conn;
    logic [ID_W-1:0]   id;
  } item_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   next_id;
    logic              applied;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              acked;
    logic [CONN_W-1:0] conn;
    logic [ID_W-1:0]   id;
  } log_ent_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_MODR,
    S_DISP,
    S_SLIST,
    S_STAIL,
    S_ALOG,
    S_ALIST,
    S_ACMP,
    S_QWAIT
  } state_t;

endpackage

/* rtl/cumulative_ack_tracker.sv */
`timescale 1ns / 1ps

// Cumulative acknowledgement tracker for heartbeat messages over up to CONNECTIONS
// connections. Each transaction on the input queue yields exactly one result on the
// output queue, in order. A sent message is logged in a window of LOG_DEPTH slots
// (slot = id modulo LOG_DEPTH) and appended to its connection's ring of LIST_DEPTH
// unacknowledged ids; an acknowledgement of a logged, unacknowledged id marks it and
// drops every entry of that ring up to and including it. A result carries the next
// message id (zero for an unused request code) and the unacknowledged count (zero for
// a bad connection, an unused code or an unknown id). After reset a clearing pass over
// the log and list-state memories runs, during which in_full is held high. A front end
// classifies transactions into a two-entry queue, and a back-end sequencer works
// through the log, list-state and id memories, all with registered reads. In the back
// end a bad connection or an unused request code finishes at dispatch and a query
// after its list-state read; a sent message writes the log, reads its list state and,
// when the list is not empty, its tail id; an acknowledgement reads the log and ends
// there when the id is unknown, ends after the list-state read when it is repeated or
// the list is empty, and otherwise scans the list one entry at a time through the
// single read port of the id memory. When LOG_DEPTH is not a power of two the slot is
// found by four reciprocal multiply steps, each a multiply and a correction state, one
// per 16-bit chunk of the id. A result is held on the output ports until it is popped,
// and the back end starts the next transaction once its output register is free.

module cumulative_ack_tracker #(
  parameter int CONNECTIONS = cat_pkg::CONNECTIONS_DEF,
  parameter int LOG_DEPTH   = cat_pkg::LOG_DEPTH_DEF,
  parameter int LIST_DEPTH  = cat_pkg::LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [cat_pkg::REQ_W-1:0]     in_req_type,
  input  logic [cat_pkg::CONN_W-1:0]    in_connection,
  input  logic [cat_pkg::ID_W-1:0]      in_message_id,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [cat_pkg::CNT_W-1:0]     out_unacked_count,
  output logic [cat_pkg::ID_W-1:0]      out_next_id,
  output logic                          out_ack_applied,
  output logic [cat_pkg::STAT_W-1:0]    out_status
);

  logic                deq_valid;
  cat_pkg::item_t      deq_item;
  cat_pkg::back_stat_t back_stat;
  cat_pkg::result_t    res;

  // Front end: classification and the short queue towards the sequencer.
  cat_front #(.CONNECTIONS(CONNECTIONS)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_req_type(in_req_type),
    .in_connection(in_connection),
    .in_message_id(in_message_id),
    .deq_valid(deq_valid),
    .deq_item(deq_item),
    .back_stat(back_stat)
  );

  // Back end: sequencer over the memories, with the output register.
  cat_back #(
    .CONNECTIONS(CONNECTIONS),
    .LOG_DEPTH(LOG_DEPTH),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .deq_valid(deq_valid),
    .deq_item(deq_item),
    .back_stat(back_stat),
    .out_pop(out_pop),
    .out_empty(out_empty),
    .out_res(res)
  );

  assign out_unacked_count = res.count;
  assign out_next_id       = res.next_id;
  assign out_ack_applied   = res.applied;
  assign out_status        = res.status;

endmodule

/* rtl/cat_ram.sv */
`timescale 1ns / 1ps

module cat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/cat_front.sv */
`timescale 1ns / 1ps

module cat_front #(
  parameter int CONNECTIONS = cat_pkg::CONNECTIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cat_pkg::REQ_W-1:0]    in_req_type,
  input  logic [cat_pkg::CONN_W-1:0]   in_connection,
  input  logic [cat_pkg::ID_W-1:0]     in_message_id,
  output logic                         deq_valid,
  output cat_pkg::item_t               deq_item,
  input  cat_pkg::back_stat_t          back_stat
);

  cat_pkg::item_t q_r [2];
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  cat_pkg::item_t cls;
  logic           conn_ok;
  logic           push_ok;
  logic           pop_ok;

  // Classify the incoming transaction so the back end only dispatches.
  always_comb begin
    conn_ok  = 32'(in_connection) < CONNECTIONS;
    cls.conn = in_connection;
    cls.id   = in_message_id;
    unique case (in_req_type)
      cat_pkg::REQ_SENT:  cls.op = conn_ok ? cat_pkg::OP_SENT : cat_pkg::OP_BADCONN;
      cat_pkg::REQ_ACK:   cls.op = cat_pkg::OP_ACK;
      cat_pkg::REQ_QUERY: cls.op = conn_ok ? cat_pkg::OP_QUERY : cat_pkg::OP_BADCONN;
      default:            cls.op = cat_pkg::OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2) || back_stat.clearing;
  assign push_ok   = in_push && !in_full;
  assign deq_valid = cnt_r != 2'd0;
  assign deq_item  = q_r[rd_r];
  assign pop_ok    = deq_valid && back_stat.ready;

  always_comb begin
    wr_nxt  = wr_r ^ push_ok;
    rd_nxt  = rd_r ^ pop_ok;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

/* rtl/cat_back.sv */
`timescale 1ns / 1ps

module cat_back #(
  parameter int CONNECTIONS = cat_pkg::CONNECTIONS_DEF,
  parameter int LOG_DEPTH   = cat_pkg::LOG_DEPTH_DEF,
  parameter int LIST_DEPTH  = cat_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                deq_valid,
  input  cat_pkg::item_t      deq_item,
  output cat_pkg::back_stat_t back_stat,
  input  logic                out_pop,
  output logic                out_empty,
  output cat_pkg::result_t    out_res
);

  localparam int LAW = $clog2(LOG_DEPTH);
  localparam int CIW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int HW  = $clog2(LIST_DEPTH);
  localparam int NW  = $clog2(LIST_DEPTH + 1);
  localparam int MAXD = (LOG_DEPTH > CONNECTIONS) ? LOG_DEPTH : CONNECTIONS;
  localparam int CLW = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int IDS_DEPTH = (1 << CIW) * (1 << HW);
  localparam int LOG_W = $bits(cat_pkg::log_ent_t);
  localparam int LST_W = HW + NW;
  localparam bit LOG_POW2 = (LOG_DEPTH & (LOG_DEPTH - 1)) == 0;
  localparam logic [1:0]  MLAST = 2'd3;
  localparam logic [31:0] DEP32 = 32'(LOG_DEPTH);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LOG_DEPTH));

  cat_pkg::state_t   state_r, state_nxt;
  cat_pkg::item_t    item_r, item_nxt;
  logic [LAW-1:0]    slot_r, slot_nxt;
  logic [1:0]        mcnt_r, mcnt_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [HW-1:0]     head_r, head_nxt;
  logic [HW-1:0]     p_r, p_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     k_r, k_nxt;
  logic [CIW-1:0]    lconn_r, lconn_nxt;
  logic              acked_r, acked_nxt;
  logic [cat_pkg::ID_W-1:0] last_id_r, last_id_nxt;
  logic              any_r, any_nxt;
  logic [CLW-1:0]    clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  cat_pkg::result_t  out_r, out_nxt;

  logic              log_we, lst_we, ids_we;
  logic [LAW-1:0]    log_waddr, log_raddr;
  logic [CIW-1:0]    lst_waddr, lst_raddr;
  logic [CIW+HW-1:0] ids_waddr, ids_raddr;
  cat_pkg::log_ent_t log_wdata, log_rdata;
  logic [LST_W-1:0]  lst_wdata, lst_rdata;
  logic [cat_pkg::ID_W-1:0] ids_wdata, ids_rdata;

  logic [31:0]       mod_v;
  logic [31:0]       mod_qd;
  logic [31:0]       mod_rem;
  logic [HW-1:0]     rd_head;
  logic [NW-1:0]     rd_n;
  logic [CIW-1:0]    icidx;
  logic [cat_pkg::ID_W-1:0] next_id_now;
  logic              fin;
  logic [NW-1:0]     fin_cnt;
  logic              fin_app;
  logic [cat_pkg::STAT_W-1:0] fin_stat;
  logic [NW-1:0]     k1;

  function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] a, input logic [NW-1:0] b);
    logic [NW:0] s;
    s = (NW+1)'(a) + (NW+1)'(b);
    if (s >= (NW+1)'(LIST_DEPTH)) begin
      s = s - (NW+1)'(LIST_DEPTH);
    end
    return HW'(s);
  endfunction

  cat_ram #(.WIDTH(LOG_W), .DEPTH(LOG_DEPTH)) u_log (
    .clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
    .raddr(log_raddr), .rdata_r(log_rdata)
  );

  cat_ram #(.WIDTH(LST_W), .DEPTH(CONNECTIONS)) u_lst (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata_r(lst_rdata)
  );

  cat_ram #(.WIDTH(cat_pkg::ID_W), .DEPTH(IDS_DEPTH)) u_ids (
    .clk(clk), .we(ids_we), .waddr(ids_waddr), .wdata(ids_wdata),
    .raddr(ids_raddr), .rdata_r(ids_rdata)
  );

  assign rd_head     = lst_rdata[LST_W-1:NW];
  assign rd_n        = lst_rdata[NW-1:0];
  assign icidx       = CIW'(item_r.conn);
  assign next_id_now = any_r ? last_id_r + 64'd1 : 64'd0;
  assign back_stat.ready    = (state_r == cat_pkg::S_IDLE) && !out_valid_r;
  assign back_stat.clearing = state_r == cat_pkg::S_CLEAR;
  assign out_empty = !out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    slot_nxt    = slot_r;
    mcnt_nxt    = mcnt_r;
    prod_nxt    = prod_r;
    head_nxt    = head_r;
    p_nxt       = p_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    lconn_nxt   = lconn_r;
    acked_nxt   = acked_r;
    last_id_nxt = last_id_r;
    any_nxt     = any_r;
    clr_nxt     = clr_r;
    log_we      = 1'b0;
    log_waddr   = slot_r;
    log_wdata   = '0;
    log_raddr   = slot_r;
    lst_we      = 1'b0;
    lst_waddr   = icidx;
    lst_wdata   = '0;
    lst_raddr   = icidx;
    ids_we      = 1'b0;
    ids_waddr   = {icidx, ring_add(head_r, n_r)};
    ids_wdata   = item_r.id;
    ids_raddr   = {icidx, head_r};
    fin         = 1'b0;
    fin_cnt     = '0;
    fin_app     = 1'b0;
    fin_stat    = cat_pkg::STAT_OK;
    mod_v       = {16'(slot_r), item_r.id[cat_pkg::ID_W-1 - 16*mcnt_r -: 16]};
    mod_qd      = '0;
    mod_rem     = '0;
    k1          = k_r + NW'(1);

    unique case (state_r)
      cat_pkg::S_CLEAR: begin
        log_waddr = LAW'(clr_r);
        lst_waddr = CIW'(clr_r);
        log_we    = 32'(clr_r) < LOG_DEPTH;
        lst_we    = 32'(clr_r) < CONNECTIONS;
        if (32'(clr_r) == MAXD - 1) begin
          state_nxt = cat_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + CLW'(1);
        end
      end
      cat_pkg::S_IDLE: begin
        if (deq_valid && !out_valid_r) begin
          item_nxt = deq_item;
          mcnt_nxt = '0;
          slot_nxt = LOG_POW2 ? LAW'(deq_item.id) : '0;
          lst_raddr = CIW'(deq_item.conn);
          case (deq_item.op)
            cat_pkg::OP_SENT, cat_pkg::OP_ACK: begin
              state_nxt = LOG_POW2 ? cat_pkg::S_DISP : cat_pkg::S_MOD;
            end
            cat_pkg::OP_QUERY: state_nxt = cat_pkg::S_QWAIT;
            cat_pkg::OP_BADCONN: begin
              fin      = 1'b1;
              fin_stat = cat_pkg::STAT_BADCONN;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      cat_pkg::S_MOD: begin
        // Estimate the quotient of remainder:chunk by a reciprocal multiply.
        prod_nxt  = mod_v * RECIP;
        state_nxt = cat_pkg::S_MODR;
      end
      cat_pkg::S_MODR: begin
        // The estimate is at most one short, so one correction suffices.
        mod_qd  = prod_r[63:32] * DEP32;
        mod_rem = mod_v - mod_qd;
        if (mod_rem >= DEP32) begin
          mod_rem = mod_rem - DEP32;
        end
        slot_nxt = LAW'(mod_rem);
        if (mcnt_r == MLAST) begin
          state_nxt = cat_pkg::S_DISP;
        end else begin
          mcnt_nxt  = mcnt_r + 2'd1;
          state_nxt = cat_pkg::S_MOD;
        end
      end
      cat_pkg::S_DISP: begin
        if (item_r.op == cat_pkg::OP_SENT) begin
          log_we    = 1'b1;
          log_wdata = '{valid: 1'b1, acked: 1'b0, conn: item_r.conn, id: item_r.id};
          if (!any_r || item_r.id > last_id_r) begin
            last_id_nxt = item_r.id;
          end
          any_nxt   = 1'b1;
          state_nxt = cat_pkg::S_SLIST;
        end else begin
          state_nxt = cat_pkg::S_ALOG;
        end
      end
      cat_pkg::S_SLIST: begin
        head_nxt  = rd_head;
        n_nxt     = rd_n;
        ids_raddr = {icidx, ring_add(rd_head, rd_n - NW'(1))};
        if (rd_n != '0) begin
          state_nxt = cat_pkg::S_STAIL;
        end else begin
          ids_we    = 1'b1;
          ids_waddr = {icidx, rd_head};
          lst_we    = 1'b1;
          lst_wdata = {rd_head, NW'(1)};
          fin       = 1'b1;
          fin_cnt   = NW'(1);
        end
      end
      cat_pkg::S_STAIL: begin
        fin = 1'b1;
        if (ids_rdata == item_r.id) begin
          fin_cnt = n_r;
        end else if (32'(n_r) >= LIST_DEPTH) begin
          fin_cnt  = n_r;
          fin_stat = cat_pkg::STAT_FULL;
        end else begin
          ids_we    = 1'b1;
          lst_we    = 1'b1;
          lst_wdata = {head_r, n_r + NW'(1)};
          fin_cnt   = n_r + NW'(1);
        end
      end
      cat_pkg::S_ALOG: begin
        lconn_nxt = CIW'(log_rdata.conn);
        acked_nxt = log_rdata.acked;
        lst_raddr = CIW'(log_rdata.conn);
        if (!log_rdata.valid || log_rdata.id != item_r.id ||
            32'(log_rdata.conn) >= CONNECTIONS) begin
          fin = 1'b1;
        end else begin
          state_nxt = cat_pkg::S_ALIST;
        end
      end
      cat_pkg::S_ALIST: begin
        head_nxt  = rd_head;
        n_nxt     = rd_n;
        k_nxt     = '0;
        p_nxt     = rd_head;
        ids_raddr = {lconn_r, rd_head};
        if (acked_r) begin
          fin     = 1'b1;
          fin_cnt = rd_n;
        end else begin
          log_we    = 1'b1;
          log_wdata = '{valid: 1'b1, acked: 1'b1, conn: item_r.conn, id: item_r.id};
          log_wdata.conn = cat_pkg::CONN_W'(lconn_r);
          if (rd_n == '0) begin
            fin     = 1'b1;
            fin_app = 1'b1;
          end else begin
            state_nxt = cat_pkg::S_ACMP;
          end
        end
      end
      cat_pkg::S_ACMP: begin
        // Read of entry k is in flight; the next one is issued behind it.
        ids_raddr = {lconn_r, ring_add(p_r, NW'(1))};
        lst_waddr = lconn_r;
        if (ids_rdata == item_r.id) begin
          lst_we    = 1'b1;
          lst_wdata = {ring_add(p_r, NW'(1)), n_r - k1};
          fin       = 1'b1;
          fin_app   = 1'b1;
          fin_cnt   = n_r - k1;
        end else if (k1 == n_r) begin
          fin     = 1'b1;
          fin_app = 1'b1;
          fin_cnt = n_r;
        end else begin
          k_nxt = k1;
          p_nxt = ring_add(p_r, NW'(1));
        end
      end
      cat_pkg::S_QWAIT: begin
        fin     = 1'b1;
        fin_cnt = rd_n;
      end
      default: state_nxt = cat_pkg::S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    if (fin) begin
      if (state_r != cat_pkg::S_IDLE) begin
        state_nxt = cat_pkg::S_IDLE;
      end
      out_valid_nxt   = 1'b1;
      out_nxt.count   = cat_pkg::CNT_W'(fin_cnt);
      out_nxt.applied = fin_app;
      out_nxt.status  = fin_stat;
      out_nxt.next_id = next_id_now;
      if (state_r == cat_pkg::S_IDLE && deq_item.op == cat_pkg::OP_NOP) begin
        out_nxt.next_id = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cat_pkg::S_CLEAR;
      clr_r       <= '0;
      last_id_r   <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      last_id_r   <= last_id_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    slot_r  <= slot_nxt;
    mcnt_r  <= mcnt_nxt;
    prod_r  <= prod_nxt;
    head_r  <= head_nxt;
    p_r     <= p_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    lconn_r <= lconn_nxt;
    acked_r <= acked_nxt;
    out_r   <= out_nxt;
  end

endmodule

/* rtl/cat_checker.sv */
`timescale 1ns / 1ps

module cat_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_push,
  input logic                       in_full,
  input logic                       out_pop,
  input logic                       out_empty,
  input logic [cat_pkg::CNT_W-1:0]  out_unacked_count,
  input logic [cat_pkg::ID_W-1:0]   out_next_id,
  input logic                       out_ack_applied,
  input logic [cat_pkg::STAT_W-1:0] out_status
);

  // No result may survive a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_next_id) &&
      $stable(out_unacked_count) && $stable(out_status) && $stable(out_ack_applied))
    else $error("waiting result changed");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status == cat_pkg::STAT_OK || out_status == cat_pkg::STAT_FULL ||
      out_status == cat_pkg::STAT_BADCONN)
    else $error("illegal status code");

  a_applied_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_ack_applied |-> out_status == cat_pkg::STAT_OK)
    else $error("applied acknowledgement with error status");

  a_badconn_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == cat_pkg::STAT_BADCONN |->
      out_unacked_count == '0 && !out_ack_applied)
    else $error("bad connection result carries a count");

endmodule

bind cumulative_ack_tracker cat_checker u_cat_checker (.*);

/* test/ack_tracker_checker.sv */
`timescale 1ns / 1ps

module ack_tracker_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [cat_pkg::REQ_W-1:0]  in_req_type,
  input  logic [cat_pkg::CONN_W-1:0] in_connection,
  input  logic [cat_pkg::ID_W-1:0]   in_message_id,
  input  logic                       out_pop,
  input  logic                       out_empty,
  input  logic [cat_pkg::CNT_W-1:0]  out_unacked_count,
  input  logic [cat_pkg::ID_W-1:0]   out_next_id,
  input  logic                       out_ack_applied,
  input  logic [cat_pkg::STAT_W-1:0] out_status,
  output int                         fail_count,
  output int                         pending
);

  localparam int NCONN = cat_pkg::CONNECTIONS_DEF;
  localparam int NLOG  = cat_pkg::LOG_DEPTH_DEF;
  localparam int NLIST = cat_pkg::LIST_DEPTH_DEF;

  typedef struct packed {
    logic [cat_pkg::CNT_W-1:0]  count;
    logic [cat_pkg::ID_W-1:0]   next_id;
    logic                       applied;
    logic [cat_pkg::STAT_W-1:0] status;
  } reply_t;

  // Shadow copy of the tracker state.
  bit                       sh_valid [NLOG];
  bit                       sh_acked [NLOG];
  bit [cat_pkg::CONN_W-1:0] sh_conn  [NLOG];
  bit [cat_pkg::ID_W-1:0]   sh_id    [NLOG];
  bit [cat_pkg::ID_W-1:0]   sh_ring  [NCONN][NLIST];
  int                       sh_head  [NCONN];
  int                       sh_count [NCONN];
  bit [cat_pkg::ID_W-1:0]   sh_last;
  bit                       sh_any;

  reply_t replies_due[$];

  function automatic reply_t track_item(bit [cat_pkg::REQ_W-1:0] req,
                                        bit [cat_pkg::CONN_W-1:0] c,
                                        bit [cat_pkg::ID_W-1:0] id);
    reply_t r;
    int slot, n, k;
    bit [cat_pkg::CONN_W-1:0] lc;
    r = '0;
    slot = int'(id % NLOG);
    if (req == cat_pkg::REQ_SENT) begin
      if (c >= NCONN) begin
        r.status = cat_pkg::STAT_BADCONN;
      end else begin
        sh_valid[slot] = 1; sh_acked[slot] = 0; sh_conn[slot] = c; sh_id[slot] = id;
        if (!sh_any || id > sh_last) sh_last = id;
        sh_any = 1;
        n = sh_count[c];
        if (n > 0 && sh_ring[c][(sh_head[c] + n - 1) % NLIST] == id) begin
          r.count = cat_pkg::CNT_W'(n);
        end else if (n >= NLIST) begin
          r.status = cat_pkg::STAT_FULL;
          r.count = cat_pkg::CNT_W'(NLIST);
        end else begin
          sh_ring[c][(sh_head[c] + n) % NLIST] = id;
          sh_count[c] = n + 1;
          r.count = cat_pkg::CNT_W'(n + 1);
        end
      end
    end else if (req == cat_pkg::REQ_ACK) begin
      if (sh_valid[slot] && sh_id[slot] == id) begin
        lc = sh_conn[slot];
        if (sh_acked[slot]) begin
          r.count = cat_pkg::CNT_W'(sh_count[lc]);
        end else begin
          sh_acked[slot] = 1;
          r.applied = 1;
          n = sh_count[lc];
          for (k = 0; k < n; k++) begin
            if (sh_ring[lc][(sh_head[lc] + k) % NLIST] == id) begin
              sh_head[lc] = (sh_head[lc] + k + 1) % NLIST;
              sh_count[lc] = n - (k + 1);
              break;
            end
          end
          r.count = cat_pkg::CNT_W'(sh_count[lc]);
        end
      end
    end else if (req == cat_pkg::REQ_QUERY) begin
      if (c >= NCONN) r.status = cat_pkg::STAT_BADCONN;
      else r.count = cat_pkg::CNT_W'(sh_count[c]);
    end
    if (req != cat_pkg::REQ_UNUSED) r.next_id = sh_any ? sh_last + 64'd1 : '0;
    return r;
  endfunction

  assign pending = replies_due.size();

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      fail_count <= 0;
      replies_due.delete();
      sh_valid = '{default: 0};
      sh_acked = '{default: 0};
      sh_head = '{default: 0};
      sh_count = '{default: 0};
      sh_last = '0;
      sh_any = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (replies_due.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result transaction at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = replies_due.pop_front();
          if (want.count !== out_unacked_count || want.next_id !== out_next_id ||
              want.applied !== out_ack_applied || want.status !== out_status) begin
            if (fail_count < 10)
              $display({"Mismatch at %0t: expected cnt %0d nid %h app %0d st %0d,",
                        " got cnt %0d nid %h app %0d st %0d"},
                       $realtime, want.count, want.next_id, want.applied, want.status,
                       out_unacked_count, out_next_id, out_ack_applied, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full)
        replies_due = {replies_due, track_item(in_req_type, in_connection, in_message_id)};
    end
  end
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  logic                       clk = 0;
  logic                       rst_n = 0;
  logic                       in_push = 0;
  logic                       in_full;
  logic [cat_pkg::REQ_W-1:0]  in_req_type = cat_pkg::REQ_QUERY;
  logic [cat_pkg::CONN_W-1:0] in_connection = '0;
  logic [cat_pkg::ID_W-1:0]   in_message_id = '0;
  logic                       out_pop = 0;
  logic                       out_empty;
  logic [cat_pkg::CNT_W-1:0]  out_unacked_count;
  logic [cat_pkg::ID_W-1:0]   out_next_id;
  logic                       out_ack_applied;
  logic [cat_pkg::STAT_W-1:0] out_status;
  int                         fail_count, pending;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct = 36;
  int take_idle_pct = 88;

  // The last 300 ids sent, newest last, so that acks mostly hit live messages.
  logic [cat_pkg::ID_W-1:0] sent_ids[$];
  logic [cat_pkg::ID_W-1:0] id_cursor;

  cumulative_ack_tracker DUT (.*);

  ack_tracker_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver pops at random; it redraws its pop every cycle.
  always @(posedge clk) out_pop <= ($urandom_range(99) >= take_idle_pct);

  // Offers one transaction, with random gaps beforehand, and waits for it to be taken.
  task automatic send_item(logic [cat_pkg::REQ_W-1:0] req, logic [cat_pkg::CONN_W-1:0] c,
                           logic [cat_pkg::ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_req_type <= req;
    in_connection <= c;
    in_message_id <= id;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (req == cat_pkg::REQ_SENT) sent_ids = {sent_ids, id};
    if (sent_ids.size() > 300) void'(sent_ids.pop_front());
  endtask

  // One item of mostly well-formed traffic: new ids in rising order, acks of recent
  // ids (so that cumulative drops happen), queries and some noise.
  task automatic random_item();
    int pick;
    logic [cat_pkg::ID_W-1:0] id;
    pick = $urandom_range(99);
    if (pick < 45) begin
      id_cursor = id_cursor + 64'($urandom_range(1, 3));
      send_item(cat_pkg::REQ_SENT, cat_pkg::CONN_W'($urandom_range(0, 3)), id_cursor);
    end else if (pick < 75 && sent_ids.size() > 0) begin
      id = sent_ids[$urandom_range(sent_ids.size() - 1)];
      send_item(cat_pkg::REQ_ACK, cat_pkg::CONN_W'($urandom_range(15)), id);
    end else if (pick < 85) begin
      send_item(cat_pkg::REQ_QUERY, cat_pkg::CONN_W'($urandom_range(15)),
                {$urandom, $urandom});
    end else if (pick < 92) begin
      send_item(cat_pkg::REQ_ACK, cat_pkg::CONN_W'($urandom_range(15)),
                {$urandom, $urandom});
    end else if (pick < 96) begin
      send_item(cat_pkg::REQ_SENT, cat_pkg::CONN_W'($urandom_range(15)),
                {$urandom, $urandom});
    end else begin
      send_item(cat_pkg::REQ_UNUSED, cat_pkg::CONN_W'($urandom_range(15)),
                {$urandom, $urandom});
    end
  endtask

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: empty tracker, extremes of the id, full list, acks of every kind.
    send_item(cat_pkg::REQ_QUERY, 4'd0, '0);
    send_item(cat_pkg::REQ_ACK, 4'd0, 64'd5);
    send_item(cat_pkg::REQ_UNUSED, 4'd15, '1);
    send_item(cat_pkg::REQ_SENT, 4'd15, '1);
    send_item(cat_pkg::REQ_SENT, 4'd15, '1);
    send_item(cat_pkg::REQ_QUERY, 4'd15, '0);
    send_item(cat_pkg::REQ_ACK, 4'd0, '1);
    send_item(cat_pkg::REQ_ACK, 4'd0, '1);
    send_item(cat_pkg::REQ_SENT, 4'd2, 64'd10);
    send_item(cat_pkg::REQ_SENT, 4'd2, 64'd4);
    send_item(cat_pkg::REQ_SENT, 4'd2, 64'd266);
    send_item(cat_pkg::REQ_ACK, 4'd0, 64'd10);
    send_item(cat_pkg::REQ_ACK, 4'd0, 64'd4);
    send_item(cat_pkg::REQ_ACK, 4'd0, 64'd266);
    send_item(cat_pkg::REQ_QUERY, 4'd2, '0);
    // Fill connection 7 past its list depth, then drop most of it with one ack.
    for (i = 0; i < cat_pkg::LIST_DEPTH_DEF + 2; i++)
      send_item(cat_pkg::REQ_SENT, 4'd7, 64'd1000 + 64'(i));
    send_item(cat_pkg::REQ_ACK, 4'd3, 64'(1000 + cat_pkg::LIST_DEPTH_DEF - 3));
    send_item(cat_pkg::REQ_QUERY, 4'd7, '0);

    id_cursor = 64'd2000;
    for (i = 0; i < 800; i++) begin
      if (i == 300) begin
        send_idle_pct = 88;
        take_idle_pct = 36;
      end else if (i == 550) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      random_item();
    end
    in_push <= 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* cumulative_ack_tracker.f */
rtl/cat_pkg.sv
rtl/cat_ram.sv
rtl/cat_front.sv
rtl/cat_back.sv
rtl/cumulative_ack_tracker.sv
rtl/cat_checker.sv
test/ack_tracker_checker.sv
test/tb.sv
